// ===== hw/rtl/mips_integer_execute_unit_core_defines.svh =====
// Assertion macros used by the execute unit controller (mieu_ctrl).
// Expects aclk and aresetn in the scope of each use.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_CORE_DEFINES_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_CORE_DEFINES_SVH
`define MIEU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define MIEU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/mieu_pkg.sv =====
// Shared types, codes and constants for the MIPS32 integer execute unit.
// Used by every module of the block; depends on nothing.
package mieu_pkg;

    localparam int XLEN          = 32;
    localparam int NUM_REGS      = 32;
    localparam int MEM_BYTES_DEF = 65536;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 168;

    localparam logic [31:0] DATA_BASE = 32'h1000_0000;

    localparam logic [1:0] OP_EXEC    = 2'd0;
    localparam logic [1:0] OP_PRELOAD = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_ADDR    = 3'd2;
    localparam logic [2:0] ST_DIV0    = 3'd3;
    localparam logic [2:0] ST_HALTED  = 3'd4;

    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_ADDI    = 6'd8;
    localparam logic [5:0] OPC_ADDIU   = 6'd9;
    localparam logic [5:0] OPC_SLTI    = 6'd10;
    localparam logic [5:0] OPC_SLTIU   = 6'd11;
    localparam logic [5:0] OPC_ANDI    = 6'd12;
    localparam logic [5:0] OPC_ORI     = 6'd13;
    localparam logic [5:0] OPC_XORI    = 6'd14;
    localparam logic [5:0] OPC_LUI     = 6'd15;
    localparam logic [5:0] OPC_LB      = 6'd32;
    localparam logic [5:0] OPC_LH      = 6'd33;
    localparam logic [5:0] OPC_LW      = 6'd35;
    localparam logic [5:0] OPC_LBU     = 6'd36;
    localparam logic [5:0] OPC_LHU     = 6'd37;
    localparam logic [5:0] OPC_SB      = 6'd40;
    localparam logic [5:0] OPC_SH      = 6'd41;
    localparam logic [5:0] OPC_SW      = 6'd43;

    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_SLLV  = 6'd4;
    localparam logic [5:0] FN_SRLV  = 6'd6;
    localparam logic [5:0] FN_SRAV  = 6'd7;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MTHI  = 6'd17;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MTLO  = 6'd19;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_DIV   = 6'd26;
    localparam logic [5:0] FN_DIVU  = 6'd27;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_SUBU  = 6'd35;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_NOR   = 6'd39;
    localparam logic [5:0] FN_SLT   = 6'd42;
    localparam logic [5:0] FN_SLTU  = 6'd43;

    localparam logic [5:0] SEL_HI = 6'd32;
    localparam logic [5:0] SEL_LO = 6'd33;
    localparam logic [5:0] SEL_PC = 6'd34;

    typedef enum logic [2:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV,
        KIND_LOAD,
        KIND_STORE
    } kind_t;

    typedef struct packed {
        logic load_in;
        logic rd_regs;
        logic mul_start;
        logic div_start;
        logic mem_start;
        logic mem_rd;
        logic mem_cap;
        logic mem_wr;
        logic clr_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  mem_last;
        logic  div_busy;
        logic  clr_last;
        logic  out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/mips_integer_execute_unit_core.sv =====
// Every item passes RDREG and EXEC and ends in COMMIT; ALU, shift, HI/LO, mult, preload, read
// and restart go from EXEC straight to COMMIT. Loads add a read and a capture state per byte,
// stores a write state per byte, and div/divu by a nonzero divisor wait in DIVW on the
// one-bit-per-cycle divider. One item is in flight at a time; the next is accepted while its
// result waits in the output register. Reset (aresetn low, synchronous) is followed by a pass
// over every address that fills data memory with 0xFF, during which no item is accepted.
module mips_integer_execute_unit_core #(
    parameter int MEM_BYTES = mieu_pkg::MEM_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // instr[31:0], mem_offset[47:32], mem_byte[55:48], reg_select[61:56], zero [63:62]
    input  logic [mieu_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // reg_written[0], dest_reg[5:1], dest_value[37:6], hi_value[69:38], lo_value[101:70],
    // pc_value[133:102], read_value[165:134], zero [167:166]
    output logic [mieu_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [2:0]                       m_tuser
);
    import mieu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mieu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mieu_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== hw/rtl/mieu_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mieu_pkg for the data width.
module mieu_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mieu_pkg::XLEN-1:0] dividend,
    input  logic [mieu_pkg::XLEN-1:0] divisor,
    output logic                      busy,
    output logic [mieu_pkg::XLEN-1:0] quotient,
    output logic [mieu_pkg::XLEN-1:0] remainder
);
    import mieu_pkg::*;

    localparam int CW = $clog2(XLEN);

    logic            busy_reg;
    logic [CW-1:0]   cnt_reg;
    logic [XLEN-1:0] rem_reg;
    logic [XLEN-1:0] quo_reg;
    logic [XLEN-1:0] dvs_reg;
    logic [XLEN:0]   trial;
    logic            qbit;
    logic [XLEN-1:0] rem_step;

    assign trial    = {rem_reg, quo_reg[XLEN-1]} - {1'b0, dvs_reg};
    assign qbit     = !trial[XLEN];
    assign rem_step = qbit ? trial[XLEN-1:0] : {rem_reg[XLEN-2:0], quo_reg[XLEN-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(XLEN - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[XLEN-2:0], qbit};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/mieu_datapath.sv =====
// Datapath: register file, HI/LO/PC, decode, ALU, multiplier, data memory, result register.
// Depends on mieu_pkg and instantiates mieu_div.
module mieu_datapath #(
    parameter int MEM_BYTES = mieu_pkg::MEM_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [mieu_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mieu_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]                       m_tuser,
    input  mieu_pkg::dp_cmd_t                cmd,
    output mieu_pkg::dp_stat_t               stat
);
    import mieu_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [16:0] MEM_LIM17 = 17'(MEM_BYTES);
    localparam logic [31:0] MEM_LIM32 = 32'(MEM_BYTES);

    logic [1:0]  op_reg;
    logic [31:0] instr_reg;
    logic [15:0] moff_reg;
    logic [7:0]  mbyte_reg;
    logic [5:0]  sel_reg;

    logic [31:0] gpr_mem [NUM_REGS];
    logic [NUM_REGS-1:0] gpr_vld_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic [31:0] pc_reg;
    logic        halted_reg;

    logic [63:0] prod_reg;
    logic [31:0] corr_reg;

    logic [7:0]  data_mem [MEM_BYTES];
    logic [7:0]  rd_data_reg;
    logic [31:0] load_data_reg;
    logic [1:0]  mem_cnt_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic        m_valid_reg;
    logic [2:0]  out_status_reg;
    logic        out_wr_reg;
    logic [4:0]  out_dst_reg;
    logic [31:0] out_val_reg;
    logic [31:0] out_hi_reg;
    logic [31:0] out_lo_reg;
    logic [31:0] out_pc_reg;
    logic [31:0] out_rv_reg;

    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] zimm;
    logic [4:0]  addr_a;
    logic [31:0] addr;
    logic [31:0] addr_off;
    logic [1:0]  sz_m1;
    logic        addr_ok;
    logic [AW-1:0] acc_idx;
    logic [1:0]  st_sel;
    logic [7:0]  st_byte;
    logic        pre_ok;

    logic        div_signed;
    logic [31:0] div_na;
    logic [31:0] div_nb;
    logic        div_busy;
    logic [31:0] div_q;
    logic [31:0] div_r;

    kind_t       ex_kind;
    logic [2:0]  ex_status;
    logic        ex_wr;
    logic [4:0]  ex_dst;
    logic [31:0] ex_val;
    logic        hi_we;
    logic        lo_we;
    logic [31:0] hi_new;
    logic [31:0] lo_new;

    logic [2:0]  res_status;
    logic        res_wr;
    logic [4:0]  res_dst;
    logic [31:0] res_val;
    logic [31:0] res_hi;
    logic [31:0] res_lo;
    logic [31:0] res_pc;
    logic [31:0] res_rv;
    logic        res_halt;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    assign opc  = instr_reg[31:26];
    assign rs   = instr_reg[25:21];
    assign rt   = instr_reg[20:16];
    assign rd   = instr_reg[15:11];
    assign sh   = instr_reg[10:6];
    assign fn   = instr_reg[5:0];
    assign imm  = instr_reg[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'h0000, imm};

    assign addr_a = (op_reg == OP_READ) ? sel_reg[4:0] : rs;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            instr_reg <= s_tdata[31:0];
            moff_reg  <= s_tdata[47:32];
            mbyte_reg <= s_tdata[55:48];
            sel_reg   <= s_tdata[61:56];
            op_reg    <= s_tuser;
        end
        if (cmd.rd_regs) begin
            a_reg <= (addr_a != 5'd0 && gpr_vld_reg[addr_a]) ? gpr_mem[addr_a] : 32'h0;
            b_reg <= (rt != 5'd0 && gpr_vld_reg[rt]) ? gpr_mem[rt] : 32'h0;
        end
    end

    always_comb begin
        unique case (opc) inside
            OPC_LH, OPC_LHU, OPC_SH: sz_m1 = 2'd1;
            OPC_LW, OPC_SW:          sz_m1 = 2'd3;
            default:                 sz_m1 = 2'd0;
        endcase
    end

    assign addr     = a_reg + simm;
    assign addr_off = addr - DATA_BASE;
    assign addr_ok  = (addr >= DATA_BASE) && (addr_off <= MEM_LIM32 - 32'd1 - 32'(sz_m1));
    assign acc_idx  = addr_off[AW-1:0] + AW'(mem_cnt_reg);
    assign st_sel   = sz_m1 - mem_cnt_reg;
    assign st_byte  = b_reg[{st_sel, 3'b000} +: 8];
    assign pre_ok   = {1'b0, moff_reg} < MEM_LIM17;

    assign div_signed = (fn == FN_DIV);
    assign div_na     = (div_signed && a_reg[31]) ? (32'h0 - a_reg) : a_reg;
    assign div_nb     = (div_signed && b_reg[31]) ? (32'h0 - b_reg) : b_reg;

    mieu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_na),
        .divisor   (div_nb),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            prod_reg <= 64'(a_reg) * 64'(b_reg);
            corr_reg <= (fn == FN_MULT) ?
                ((a_reg[31] ? b_reg : 32'h0) + (b_reg[31] ? a_reg : 32'h0)) : 32'h0;
        end
    end

    always_comb begin
        ex_kind   = KIND_SIMPLE;
        ex_status = ST_OK;
        ex_wr     = 1'b1;
        ex_val    = 32'h0;
        hi_we     = 1'b0;
        lo_we     = 1'b0;
        hi_new    = hi_reg;
        lo_new    = lo_reg;
        ex_dst    = (opc == OPC_SPECIAL) ? rd : rt;
        if (opc == OPC_SPECIAL) begin
            unique case (fn) inside
                FN_SLL:  ex_val = b_reg << sh;
                FN_SRL:  ex_val = b_reg >> sh;
                FN_SRA:  ex_val = $unsigned($signed(b_reg) >>> sh);
                FN_SLLV: ex_val = b_reg << a_reg[4:0];
                FN_SRLV: ex_val = b_reg >> a_reg[4:0];
                FN_SRAV: ex_val = $unsigned($signed(b_reg) >>> a_reg[4:0]);
                FN_MFHI: ex_val = hi_reg;
                FN_MFLO: ex_val = lo_reg;
                FN_MTHI: begin
                    ex_wr  = 1'b0;
                    hi_we  = 1'b1;
                    hi_new = a_reg;
                end
                FN_MTLO: begin
                    ex_wr  = 1'b0;
                    lo_we  = 1'b1;
                    lo_new = a_reg;
                end
                FN_MULT, FN_MULTU: begin
                    ex_wr   = 1'b0;
                    ex_kind = KIND_MUL;
                    hi_we   = 1'b1;
                    lo_we   = 1'b1;
                    hi_new  = prod_reg[63:32] - corr_reg;
                    lo_new  = prod_reg[31:0];
                end
                FN_DIV, FN_DIVU: begin
                    ex_wr = 1'b0;
                    if (b_reg == 32'h0) begin
                        ex_status = ST_DIV0;
                    end else begin
                        ex_kind = KIND_DIV;
                        hi_we   = 1'b1;
                        lo_we   = 1'b1;
                        lo_new  = (div_signed && (a_reg[31] ^ b_reg[31])) ?
                                  (32'h0 - div_q) : div_q;
                        hi_new  = (div_signed && a_reg[31]) ? (32'h0 - div_r) : div_r;
                    end
                end
                FN_ADD, FN_ADDU: ex_val = a_reg + b_reg;
                FN_SUB, FN_SUBU: ex_val = a_reg - b_reg;
                FN_AND:  ex_val = a_reg & b_reg;
                FN_OR:   ex_val = a_reg | b_reg;
                FN_XOR:  ex_val = a_reg ^ b_reg;
                FN_NOR:  ex_val = ~(a_reg | b_reg);
                FN_SLT:  ex_val = {31'h0, $signed(a_reg) < $signed(b_reg)};
                FN_SLTU: ex_val = {31'h0, a_reg < b_reg};
                default: begin
                    ex_wr     = 1'b0;
                    ex_status = ST_UNKNOWN;
                end
            endcase
        end else begin
            unique case (opc) inside
                OPC_ADDI, OPC_ADDIU: ex_val = a_reg + simm;
                OPC_SLTI:  ex_val = {31'h0, $signed(a_reg) < $signed(simm)};
                OPC_SLTIU: ex_val = {31'h0, a_reg < simm};
                OPC_ANDI:  ex_val = a_reg & zimm;
                OPC_ORI:   ex_val = a_reg | zimm;
                OPC_XORI:  ex_val = a_reg ^ zimm;
                OPC_LUI:   ex_val = {imm, 16'h0000};
                OPC_LB, OPC_LBU, OPC_LH, OPC_LHU, OPC_LW: begin
                    if (!addr_ok) begin
                        ex_wr     = 1'b0;
                        ex_status = ST_ADDR;
                    end else begin
                        ex_kind = KIND_LOAD;
                    end
                    unique case (opc) inside
                        OPC_LB:  ex_val = {{24{load_data_reg[7]}}, load_data_reg[7:0]};
                        OPC_LBU: ex_val = {24'h0, load_data_reg[7:0]};
                        OPC_LH:  ex_val = {{16{load_data_reg[15]}}, load_data_reg[15:0]};
                        OPC_LHU: ex_val = {16'h0, load_data_reg[15:0]};
                        default: ex_val = load_data_reg;
                    endcase
                end
                OPC_SB, OPC_SH, OPC_SW: begin
                    ex_wr = 1'b0;
                    if (!addr_ok) begin
                        ex_status = ST_ADDR;
                    end else begin
                        ex_kind = KIND_STORE;
                    end
                end
                default: begin
                    ex_wr     = 1'b0;
                    ex_status = ST_UNKNOWN;
                end
            endcase
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_wr     = 1'b0;
        res_dst    = 5'd0;
        res_val    = 32'h0;
        res_hi     = hi_reg;
        res_lo     = lo_reg;
        res_pc     = pc_reg;
        res_rv     = 32'h0;
        res_halt   = halted_reg;
        unique case (op_reg)
            OP_EXEC: begin
                if (halted_reg) begin
                    res_status = ST_HALTED;
                end else begin
                    res_status = ex_status;
                    res_wr     = ex_wr && (ex_dst != 5'd0);
                    res_dst    = res_wr ? ex_dst : 5'd0;
                    res_val    = res_wr ? ex_val : 32'h0;
                    res_hi     = hi_we ? hi_new : hi_reg;
                    res_lo     = lo_we ? lo_new : lo_reg;
                    res_pc     = pc_reg + 32'd4;
                    res_halt   = (ex_status != ST_OK);
                end
            end
            OP_PRELOAD: begin
                res_status = pre_ok ? ST_OK : ST_ADDR;
            end
            OP_READ: begin
                if (!sel_reg[5]) begin
                    res_rv = a_reg;
                end else if (sel_reg == SEL_HI) begin
                    res_rv = hi_reg;
                end else if (sel_reg == SEL_LO) begin
                    res_rv = lo_reg;
                end else if (sel_reg == SEL_PC) begin
                    res_rv = pc_reg;
                end
            end
            default: begin
                res_pc   = 32'h0;
                res_halt = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gpr_vld_reg <= '0;
            hi_reg      <= 32'h0;
            lo_reg      <= 32'h0;
            pc_reg      <= 32'h0;
            halted_reg  <= 1'b0;
        end else if (cmd.commit) begin
            hi_reg     <= res_hi;
            lo_reg     <= res_lo;
            pc_reg     <= res_pc;
            halted_reg <= res_halt;
            if (op_reg == OP_RESTART) begin
                gpr_vld_reg <= '0;
            end else if (res_wr) begin
                gpr_vld_reg[res_dst] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && res_wr) begin
            gpr_mem[res_dst] <= res_val;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = acc_idx;
        mem_wdata = st_byte;
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 8'hFF;
        end else if (cmd.mem_wr) begin
            mem_we = 1'b1;
        end else if (cmd.commit && op_reg == OP_PRELOAD && pre_ok) begin
            mem_we    = 1'b1;
            mem_waddr = moff_reg[AW-1:0];
            mem_wdata = mbyte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            data_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= data_mem[acc_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            mem_cnt_reg <= 2'd0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.mem_start) begin
                mem_cnt_reg <= 2'd0;
            end else if (cmd.mem_cap || cmd.mem_wr) begin
                mem_cnt_reg <= mem_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_start) begin
            load_data_reg <= 32'h0;
        end else if (cmd.mem_cap) begin
            load_data_reg <= {load_data_reg[23:0], rd_data_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_wr_reg     <= res_wr;
            out_dst_reg    <= res_dst;
            out_val_reg    <= res_val;
            out_hi_reg     <= res_hi;
            out_lo_reg     <= res_lo;
            out_pc_reg     <= res_pc;
            out_rv_reg     <= res_rv;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_rv_reg, out_pc_reg, out_lo_reg, out_hi_reg,
                       out_val_reg, out_dst_reg, out_wr_reg};

    always_comb begin
        stat.kind     = (op_reg == OP_EXEC && !halted_reg) ? ex_kind : KIND_SIMPLE;
        stat.mem_last = (mem_cnt_reg == sz_m1);
        stat.div_busy = div_busy;
        stat.clr_last = (clr_cnt_reg == AW'(MEM_BYTES - 1));
        stat.out_free = !m_valid_reg || m_tready;
    end

endmodule

// ===== hw/rtl/mieu_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
// Depends on mieu_pkg and the assertion macros header.
`include "mips_integer_execute_unit_core_defines.svh"
module mieu_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mieu_pkg::dp_stat_t stat,
    output mieu_pkg::dp_cmd_t  cmd
);
    import mieu_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDREG,
        S_EXEC,
        S_DIVW,
        S_MRD,
        S_MCAP,
        S_MWR,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RDREG;
                end
            end
            S_RDREG: begin
                cmd.rd_regs = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                unique case (stat.kind)
                    KIND_MUL: begin
                        cmd.mul_start = 1'b1;
                        state_next    = S_COMMIT;
                    end
                    KIND_DIV: begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIVW;
                    end
                    KIND_LOAD: begin
                        cmd.mem_start = 1'b1;
                        state_next    = S_MRD;
                    end
                    KIND_STORE: begin
                        cmd.mem_start = 1'b1;
                        state_next    = S_MWR;
                    end
                    default: state_next = S_COMMIT;
                endcase
            end
            S_DIVW: begin
                if (!stat.div_busy) begin
                    state_next = S_COMMIT;
                end
            end
            S_MRD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MCAP;
            end
            S_MCAP: begin
                cmd.mem_cap = 1'b1;
                state_next  = stat.mem_last ? S_COMMIT : S_MRD;
            end
            S_MWR: begin
                cmd.mem_wr = 1'b1;
                if (stat.mem_last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // The result register is never overwritten while it still holds an untaken item.
    `MIEU_ASSERT_IMP(a_commit_free, cmd.commit, stat.out_free, "commit with result pending")
    // Starting a divide must make the divider busy on the next cycle.
    `MIEU_ASSERT_NXT(a_div_starts, state_reg == S_EXEC && stat.kind == KIND_DIV, stat.div_busy, "divider did not start")
    // The decode must hold steady while a divide runs.
    `MIEU_ASSERT_IMP(a_div_kind, state_reg == S_DIVW, stat.kind == KIND_DIV, "decode changed during divide")
    // A store ends in commit after its last byte.
    `MIEU_ASSERT_NXT(a_store_end, state_reg == S_MWR && stat.mem_last, state_reg == S_COMMIT, "store did not finish")

endmodule

// ===== sim/tb_mips_integer_execute_unit_core.sv =====
`timescale 1ns / 1ps
// Testbench for the MIPS32 integer execute unit core.
// Self-checking: an in-bench predictor and a scoreboard class; depends on mieu_pkg and the core.
module tb_mips_integer_execute_unit_core;
    import mieu_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] pc;
        logic [31:0] rv;
    } exec_result_t;

    // Architectural state of the predictor.
    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q, pc_q;
    logic [7:0]  dmem [MEM_BYTES_DEF];
    bit          halt_q;
    int          err_count = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic bit addr_ok(input logic [31:0] a, input int n, output int idx);
        logic [31:0] off;
        if (a < DATA_BASE) return 0;
        off = a - DATA_BASE;
        if (off > MEM_BYTES_DEF - n) return 0;
        idx = off;
        return 1;
    endfunction

    function automatic logic [31:0] reg_val(input logic [4:0] i);
        return (i == 0) ? 32'd0 : gpr[i];
    endfunction

    function automatic logic [2:0] run_instr(input logic [31:0] ins, output bit wr,
                                             output logic [4:0] dst, output logic [31:0] r);
        logic [5:0] opc, fn;
        logic [4:0] sh;
        logic [31:0] a, b, se, addr, na, nb, q, m;
        logic [63:0] p;
        int idx;
        opc = ins[31:26]; fn = ins[5:0]; sh = ins[10:6];
        a = reg_val(ins[25:21]); b = reg_val(ins[20:16]);
        se = {{16{ins[15]}}, ins[15:0]};
        addr = a + se;
        r = 0; wr = 1; idx = 0;
        if (opc == OPC_SPECIAL) begin
            dst = ins[15:11];
            case (fn)
                FN_SLL: r = b << sh;
                FN_SRL: r = b >> sh;
                FN_SRA: r = $signed(b) >>> sh;
                FN_SLLV: r = b << a[4:0];
                FN_SRLV: r = b >> a[4:0];
                FN_SRAV: r = $signed(b) >>> a[4:0];
                FN_MFHI: r = hi_q;
                FN_MFLO: r = lo_q;
                FN_MTHI: begin hi_q = a; wr = 0; end
                FN_MTLO: begin lo_q = a; wr = 0; end
                FN_MULT: begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    {hi_q, lo_q} = p; wr = 0;
                end
                FN_MULTU: begin p = {32'd0, a} * {32'd0, b}; {hi_q, lo_q} = p; wr = 0; end
                FN_DIV: begin
                    wr = 0;
                    if (b == 0) return ST_DIV0;
                    na = a[31] ? -a : a; nb = b[31] ? -b : b;
                    q = na / nb; m = na % nb;
                    if (a[31] ^ b[31]) q = -q;
                    if (a[31]) m = -m;
                    lo_q = q; hi_q = m;
                end
                FN_DIVU: begin
                    wr = 0;
                    if (b == 0) return ST_DIV0;
                    lo_q = a / b; hi_q = a % b;
                end
                FN_ADD, FN_ADDU: r = a + b;
                FN_SUB, FN_SUBU: r = a - b;
                FN_AND: r = a & b;
                FN_OR: r = a | b;
                FN_XOR: r = a ^ b;
                FN_NOR: r = ~(a | b);
                FN_SLT: r = {31'd0, $signed(a) < $signed(b)};
                FN_SLTU: r = {31'd0, a < b};
                default: begin wr = 0; return ST_UNKNOWN; end
            endcase
        end else begin
            dst = ins[20:16];
            case (opc)
                OPC_ADDI, OPC_ADDIU: r = a + se;
                OPC_SLTI: r = {31'd0, $signed(a) < $signed(se)};
                OPC_SLTIU: r = {31'd0, a < se};
                OPC_ANDI: r = a & {16'd0, ins[15:0]};
                OPC_ORI: r = a | {16'd0, ins[15:0]};
                OPC_XORI: r = a ^ {16'd0, ins[15:0]};
                OPC_LUI: r = {ins[15:0], 16'd0};
                OPC_LB, OPC_LBU: begin
                    if (!addr_ok(addr, 1, idx)) begin wr = 0; return ST_ADDR; end
                    r = (opc == OPC_LB) ? {{24{dmem[idx][7]}}, dmem[idx]} : {24'd0, dmem[idx]};
                end
                OPC_LH, OPC_LHU: begin
                    if (!addr_ok(addr, 2, idx)) begin wr = 0; return ST_ADDR; end
                    r = {16'd0, dmem[idx], dmem[idx+1]};
                    if (opc == OPC_LH) r = {{16{r[15]}}, r[15:0]};
                end
                OPC_LW: begin
                    if (!addr_ok(addr, 4, idx)) begin wr = 0; return ST_ADDR; end
                    r = {dmem[idx], dmem[idx+1], dmem[idx+2], dmem[idx+3]};
                end
                OPC_SB: begin
                    wr = 0;
                    if (!addr_ok(addr, 1, idx)) return ST_ADDR;
                    dmem[idx] = b[7:0];
                end
                OPC_SH: begin
                    wr = 0;
                    if (!addr_ok(addr, 2, idx)) return ST_ADDR;
                    dmem[idx] = b[15:8]; dmem[idx+1] = b[7:0];
                end
                OPC_SW: begin
                    wr = 0;
                    if (!addr_ok(addr, 4, idx)) return ST_ADDR;
                    {dmem[idx], dmem[idx+1], dmem[idx+2], dmem[idx+3]} = b;
                end
                default: begin wr = 0; return ST_UNKNOWN; end
            endcase
        end
        if (wr && dst != 0) gpr[dst] = r;
        else wr = 0;
        return ST_OK;
    endfunction

    function automatic exec_result_t predict_item(input logic [1:0] op, input logic [63:0] d);
        exec_result_t e;
        bit wr;
        logic [4:0] dst;
        logic [31:0] val;
        logic [5:0] sel;
        e = '0; wr = 0; dst = 0; val = 0;
        sel = d[61:56];
        case (op)
            OP_EXEC: begin
                if (halt_q) e.status = ST_HALTED;
                else begin
                    e.status = run_instr(d[31:0], wr, dst, val);
                    pc_q += 4;
                    if (e.status != ST_OK) halt_q = 1;
                end
            end
            OP_PRELOAD: dmem[d[47:32]] = d[55:48];
            OP_READ: begin
                if (sel < 32) e.rv = reg_val(sel[4:0]);
                else if (sel == SEL_HI) e.rv = hi_q;
                else if (sel == SEL_LO) e.rv = lo_q;
                else if (sel == SEL_PC) e.rv = pc_q;
            end
            default: begin
                foreach (gpr[i]) gpr[i] = 0;
                pc_q = 0; halt_q = 0;
            end
        endcase
        if (wr) begin e.wr = 1; e.dst = dst; e.val = val; end
        e.hi = hi_q; e.lo = lo_q; e.pc = pc_q;
        return e;
    endfunction

    class result_board;
        exec_result_t pending[$];

        function void note_item(input logic [1:0] op, input logic [63:0] d);
            pending.push_back(predict_item(op, d));
        endfunction

        task check_result(input logic [167:0] td, input logic [2:0] tu);
            exec_result_t e;
            if (pending.size() == 0) begin
                report("unexpected item", td[31:0], 0);
                return;
            end
            e = pending.pop_front();
            if (tu !== e.status) report("status", tu, e.status);
            if (td[0] !== e.wr) report("reg_written", td[0], e.wr);
            if (td[5:1] !== e.dst) report("dest_reg", td[5:1], e.dst);
            if (td[37:6] !== e.val) report("dest_value", td[37:6], e.val);
            if (td[69:38] !== e.hi) report("hi_value", td[69:38], e.hi);
            if (td[101:70] !== e.lo) report("lo_value", td[101:70], e.lo);
            if (td[133:102] !== e.pc) report("pc_value", td[133:102], e.pc);
            if (td[165:134] !== e.rv) report("read_value", td[165:134], e.rv);
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
    logic [63:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic [167:0] m_tdata;
    logic [2:0] m_tuser;

    int src_idle = 37, dst_idle = 71;
    bit hold_off = 0;
    result_board board = new();

    mips_integer_execute_unit_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        m_tready <= !hold_off && ($urandom_range(99) >= dst_idle);
    end

    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 200000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The valid line drops only while the sender idles or drains, so that an item that
    // follows directly keeps it high.
    task automatic send_item(input logic [1:0] op, input logic [63:0] d);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= op; s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(op, d);
    endtask

    function automatic logic [63:0] pack_in(input logic [31:0] ins, input logic [15:0] off,
                                            input logic [7:0] b, input logic [5:0] sel);
        return {2'b00, sel, b, off, ins};
    endfunction

    task automatic send_exec(input logic [31:0] ins);
        send_item(OP_EXEC, pack_in(ins, 0, 0, 0));
    endtask

    function automatic logic [31:0] r_type(input logic [4:0] rs, rt, rd, sh, input logic [5:0] fn);
        return {OPC_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_type(input logic [5:0] opc, input logic [4:0] rs, rt,
                                           input logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    localparam logic [5:0] FNS [24] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
        FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD,
        FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    localparam logic [5:0] OPCS [16] = '{OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI,
        OPC_ORI, OPC_XORI, OPC_LUI, OPC_LB, OPC_LH, OPC_LW, OPC_LBU, OPC_LHU, OPC_SB,
        OPC_SH, OPC_SW};

    // Keeps $1 pointing at the data base so memory accesses usually land in range.
    task automatic random_item();
        int k;
        logic [31:0] ins;
        logic [4:0] rs;
        k = $urandom_range(99);
        rs = ($urandom_range(3) != 0) ? 5'd1 : 5'($urandom);
        if (k < 40) begin
            ins = r_type(5'($urandom_range(31)), 5'($urandom), 5'($urandom_range(2, 31)),
                         5'($urandom), FNS[$urandom_range(23)]);
            send_exec(ins);
        end else if (k < 72) begin
            ins = i_type(OPCS[$urandom_range(15)], rs, 5'($urandom_range(2, 31)),
                         ($urandom_range(3) != 0) ? 16'($urandom_range(300)) : 16'($urandom));
            send_exec(ins);
        end else if (k < 80) send_exec($urandom);
        else if (k < 86)
            send_item(OP_PRELOAD, pack_in($urandom, ($urandom_range(1) != 0) ?
                      16'($urandom_range(300)) : 16'($urandom), 8'($urandom), 6'($urandom)));
        else if (k < 96)
            send_item(OP_READ, pack_in($urandom, 16'($urandom), 8'($urandom),
                      6'($urandom_range(1) != 0 ? $urandom_range(34) : $urandom)));
        else begin
            send_item(OP_RESTART, pack_in($urandom, 16'($urandom), 8'($urandom), 6'($urandom)));
            send_exec(i_type(OPC_LUI, 0, 1, 16'h1000));
        end
    endtask

    initial begin
        hi_q = 0; lo_q = 0; pc_q = 0; halt_q = 0;
        foreach (gpr[i]) gpr[i] = 0;
        foreach (dmem[i]) dmem[i] = 8'hFF;
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // Directed items: register extremes, overflow, min/-1 divide, memory edges, faults.
        send_exec(i_type(OPC_LUI, 0, 2, 16'h8000));
        send_exec(i_type(OPC_ADDI, 0, 3, 16'hFFFF));
        send_exec(r_type(2, 3, 4, 0, FN_ADD));
        send_exec(r_type(2, 3, 0, 0, FN_DIV));
        send_exec(r_type(2, 3, 5, 0, FN_SRAV));
        send_exec(r_type(3, 3, 6, 31, FN_SRA));
        send_exec(r_type(2, 3, 0, 0, FN_MULT));
        send_exec(r_type(2, 3, 0, 0, FN_MULTU));
        send_exec(i_type(OPC_ADDI, 0, 0, 16'h1234));
        send_item(OP_READ, pack_in(0, 0, 0, 6'd0));
        send_item(OP_PRELOAD, pack_in(0, 16'hFFFF, 8'h80, 0));
        send_item(OP_PRELOAD, pack_in(32'hFFFFFFFF, 16'h0000, 8'h81, 6'h3F));
        send_exec(i_type(OPC_LUI, 0, 1, 16'h1001));
        send_exec(i_type(OPC_LB, 1, 7, 16'hFFFF));
        send_exec(i_type(OPC_LW, 1, 7, 16'hFFFD));
        send_item(OP_READ, pack_in(0, 0, 0, SEL_PC));
        send_item(OP_READ, pack_in(0, 0, 0, 6'h3F));
        send_exec(r_type(2, 0, 0, 0, FN_DIVU));
        send_exec(r_type(0, 0, 1, 0, FN_ADD));
        send_item(OP_RESTART, '1);
        send_exec(i_type(OPC_LUI, 0, 1, 16'h1000));
        send_exec(i_type(OPC_SW, 1, 2, 16'h0000));
        send_exec(i_type(OPC_LB, 1, 8, 16'h0000));
        send_exec(32'h0800_0000);
        send_item(OP_RESTART, '0);
        send_exec(i_type(OPC_LUI, 0, 1, 16'h1000));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 37 : (ph == 1) ? 71 : 0;
            dst_idle = (ph == 0) ? 71 : (ph == 1) ? 37 : 0;
            for (int i = 0; i < 375; i++) begin
                if (i == 100 && ph == 2) fork
                    begin hold_off = 1; repeat (300) @(posedge aclk); hold_off = 0; end
                join_none
                if (i == 200) drain();
                random_item();
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (err_count == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mieu_pkg.sv
hw/rtl/mieu_div.sv
hw/rtl/mieu_datapath.sv
hw/rtl/mieu_ctrl.sv
hw/rtl/mips_integer_execute_unit_core.sv
sim/tb_mips_integer_execute_unit_core.sv
